### rtl/lom_pkg.sv
`timescale 1ns / 1ps
package lom_pkg;

  localparam int QW = 20;
  localparam int TW = 16;
  localparam int PW = 24;
  localparam int SW = 32;
  localparam int XW = 6;
  localparam int AW = 9;

  localparam logic [1:0] KIND_TRADE   = 2'd0;
  localparam logic [1:0] KIND_RESTED  = 2'd1;
  localparam logic [1:0] KIND_FILLED  = 2'd2;
  localparam logic [1:0] KIND_DROPPED = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_OPP, S_LD_OPP, S_SCAN, S_DECIDE,
    S_WB_OPP, S_RD_OWN, S_LD_OWN, S_FREE, S_STATUS
  } state_t;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          clr;
    logic          wb;
    logic          load_opp;
    logic          load_own;
    logic          sell;
    logic [SW-1:0] arrival_now;
    logic          fill;
    logic [XW-1:0] fill_idx;
    logic [QW-1:0] fill_qty;
    logic          rest;
    logic [XW-1:0] rest_idx;
    logic [QW-1:0] rest_qty;
    logic [TW-1:0] rest_trader;
    logic [PW-1:0] rest_price;
  } ctrl_t;

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] price;
    logic [SW-1:0] age;
    logic [QW-1:0] qty;
    logic [TW-1:0] trader;
    logic [XW-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic          found;
    logic [XW-1:0] idx;
  } free_t;

endpackage

### rtl/lom_order_if.sv
`timescale 1ns / 1ps
interface lom_order_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] trader;
  logic [3:0]  instrument;
  logic [19:0] amount;
  logic [23:0] limit_cents;
  modport source (output valid, mode, trader, instrument, amount, limit_cents, input ready);
  modport sink (input valid, mode, trader, instrument, amount, limit_cents, output ready);
endinterface

### rtl/lom_result_if.sv
`timescale 1ns / 1ps
interface lom_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  instrument_out;
  logic [15:0] seller;
  logic [15:0] buyer;
  logic [19:0] fill_amount;
  logic [23:0] fill_cents;
  logic [31:0] trade_seq;
  logic        last;
  modport source (output valid, kind, instrument_out, seller, buyer, fill_amount,
                  fill_cents, trade_seq, last, input ready);
  modport sink (input valid, kind, instrument_out, seller, buyer, fill_amount,
                fill_cents, trade_seq, last, output ready);
endinterface

### rtl/limit_order_matcher_top.sv
`timescale 1ns / 1ps
// per in-range order, one best-price search runs down the cell chain for each fill and one more
// for the final decision, then a search of the own side for a free slot
// throughput: one order at a time, next order taken once its status word is queued
// reset: clearing pass over the 2 * NUM_INSTRUMENTS slots of the book memories, no orders taken
module limit_order_matcher_top #(
  parameter int NUM_INSTRUMENTS = 16,
  parameter int BOOK_DEPTH = 16,
  parameter int PRICE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  lom_order_if.sink    order,
  lom_result_if.source result
);
  localparam int SLOTS = 2 * NUM_INSTRUMENTS;
  localparam int CW = $clog2(SLOTS);
  localparam int DW = $clog2(BOOK_DEPTH);
  localparam logic [63:0] M64 = (64'd1 << PRICE_BITS) - 64'd1;
  localparam logic [23:0] PMASK = M64[23:0];

  lom_pkg::state_t state, state_next;
  lom_pkg::ctrl_t  ctrl;
  lom_pkg::cand_t  cand [BOOK_DEPTH+1];
  lom_pkg::free_t  fr [BOOK_DEPTH+1];

  logic [CW-1:0]  clr_cnt;
  logic [DW-1:0]  scan_cnt;
  logic [31:0]    trade_counter;
  logic [31:0]    arrival_counter;
  logic           o_sell;
  logic [15:0]    o_trader;
  logic [3:0]     o_inst;
  logic [19:0]    o_qty;
  logic [23:0]    o_price;
  logic           o_oor;

  logic           out_free;
  logic           emit;
  logic [1:0]     e_kind;
  logic [15:0]    e_seller;
  logic [15:0]    e_buyer;
  logic [19:0]    e_amt;
  logic [23:0]    e_cents;
  logic [31:0]    e_seq;
  logic           e_last;
  logic           do_fill;
  logic           take;
  logic [19:0]    tq;
  logic           match;
  lom_pkg::cand_t best;
  lom_pkg::free_t fbest;

  assign cand[0] = '0;
  assign fr[0] = '0;
  assign best = cand[BOOK_DEPTH];
  assign fbest = fr[BOOK_DEPTH];

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    lom_cell #(.IDX(i), .SLOTS(SLOTS)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cand_in  (cand[i]),
      .free_in  (fr[i]),
      .cand_out (cand[i+1]),
      .free_out (fr[i+1])
    );
  end

  assign out_free = !result.valid || result.ready;
  assign order.ready = (state == lom_pkg::S_IDLE);
  assign take = order.valid && order.ready;
  assign tq = (o_qty < best.qty) ? o_qty : best.qty;
  assign match = (o_qty != '0) && best.valid &&
                 (o_sell ? (best.price >= o_price) : (best.price <= o_price));

  always_comb begin
    state_next = state;
    ctrl = '0;
    ctrl.sell = o_sell;
    ctrl.arrival_now = arrival_counter;
    ctrl.addr = {4'b0, o_inst, ~o_sell};
    emit = 1'b0;
    do_fill = 1'b0;
    e_kind = lom_pkg::KIND_TRADE;
    e_seller = o_sell ? o_trader : 16'd0;
    e_buyer = o_sell ? 16'd0 : o_trader;
    e_amt = o_qty;
    e_cents = o_price;
    e_seq = 32'd0;
    e_last = 1'b1;
    case (state)
      lom_pkg::S_CLEAR: begin
        ctrl.clr = 1'b1;
        ctrl.addr = lom_pkg::AW'(clr_cnt);
        if (clr_cnt == CW'(SLOTS - 1)) begin
          state_next = lom_pkg::S_IDLE;
        end
      end
      lom_pkg::S_IDLE: begin
        if (take) begin
          if ({5'b0, order.instrument} >= 9'(NUM_INSTRUMENTS)) begin
            state_next = lom_pkg::S_STATUS;
          end else begin
            state_next = lom_pkg::S_RD_OPP;
          end
        end
      end
      lom_pkg::S_RD_OPP: state_next = lom_pkg::S_LD_OPP;
      lom_pkg::S_LD_OPP: begin
        ctrl.load_opp = 1'b1;
        state_next = lom_pkg::S_SCAN;
      end
      lom_pkg::S_SCAN: begin
        if (scan_cnt == DW'(BOOK_DEPTH - 1)) begin
          state_next = lom_pkg::S_DECIDE;
        end
      end
      lom_pkg::S_DECIDE: begin
        if (!match) begin
          state_next = lom_pkg::S_WB_OPP;
        end else if (out_free) begin
          emit = 1'b1;
          do_fill = 1'b1;
          e_kind = lom_pkg::KIND_TRADE;
          e_seller = o_sell ? o_trader : best.trader;
          e_buyer = o_sell ? best.trader : o_trader;
          e_amt = tq;
          e_cents = o_sell ? o_price : best.price;
          e_seq = trade_counter;
          e_last = 1'b0;
          ctrl.fill = 1'b1;
          ctrl.fill_idx = best.idx;
          ctrl.fill_qty = tq;
          state_next = lom_pkg::S_SCAN;
        end
      end
      lom_pkg::S_WB_OPP: begin
        ctrl.wb = 1'b1;
        state_next = lom_pkg::S_RD_OWN;
      end
      lom_pkg::S_RD_OWN: begin
        ctrl.addr = {4'b0, o_inst, o_sell};
        state_next = lom_pkg::S_LD_OWN;
      end
      lom_pkg::S_LD_OWN: begin
        ctrl.addr = {4'b0, o_inst, o_sell};
        ctrl.load_own = 1'b1;
        state_next = lom_pkg::S_FREE;
      end
      lom_pkg::S_FREE: begin
        ctrl.addr = {4'b0, o_inst, o_sell};
        if (scan_cnt == DW'(BOOK_DEPTH - 1)) begin
          state_next = lom_pkg::S_STATUS;
        end
      end
      lom_pkg::S_STATUS: begin
        ctrl.addr = {4'b0, o_inst, o_sell};
        if (o_oor) begin
          e_kind = lom_pkg::KIND_DROPPED;
        end else if (o_qty == '0) begin
          e_kind = lom_pkg::KIND_FILLED;
        end else if (fbest.found) begin
          e_kind = lom_pkg::KIND_RESTED;
        end else begin
          e_kind = lom_pkg::KIND_DROPPED;
        end
        if (out_free) begin
          emit = 1'b1;
          if (e_kind == lom_pkg::KIND_RESTED) begin
            ctrl.rest = 1'b1;
            ctrl.rest_idx = fbest.idx;
            ctrl.rest_qty = o_qty;
            ctrl.rest_trader = o_trader;
            ctrl.rest_price = o_price;
          end
          state_next = lom_pkg::S_IDLE;
        end
      end
      default: state_next = lom_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lom_pkg::S_CLEAR;
      clr_cnt <= '0;
      scan_cnt <= '0;
      trade_counter <= '0;
      arrival_counter <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lom_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == lom_pkg::S_SCAN || state == lom_pkg::S_FREE) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        scan_cnt <= '0;
      end
      if (do_fill) begin
        trade_counter <= trade_counter + 32'd1;
      end
      if (state == lom_pkg::S_STATUS && emit) begin
        arrival_counter <= arrival_counter + 32'd1;
      end
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_sell <= order.mode;
      o_trader <= order.trader;
      o_inst <= order.instrument;
      o_qty <= order.amount;
      o_price <= order.limit_cents & PMASK;
      o_oor <= ({5'b0, order.instrument} >= 9'(NUM_INSTRUMENTS));
    end else if (do_fill) begin
      o_qty <= o_qty - tq;
    end
    if (emit) begin
      result.kind <= e_kind;
      result.instrument_out <= o_inst;
      result.seller <= e_seller;
      result.buyer <= e_buyer;
      result.fill_amount <= (e_kind == lom_pkg::KIND_FILLED) ? 20'd0 : e_amt;
      result.fill_cents <= e_cents;
      result.trade_seq <= e_seq;
      result.last <= e_last;
    end
  end
endmodule

### rtl/lom_ram.sv
`timescale 1ns / 1ps
module lom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### rtl/lom_cell.sv
`timescale 1ns / 1ps
module lom_cell #(
  parameter int IDX = 0,
  parameter int SLOTS = 32
) (
  input  logic           clk,
  input  lom_pkg::ctrl_t ctrl,
  input  lom_pkg::cand_t cand_in,
  input  lom_pkg::free_t free_in,
  output lom_pkg::cand_t cand_out,
  output lom_pkg::free_t free_out
);
  localparam int RAW = $clog2(SLOTS);
  localparam int WW = lom_pkg::QW + lom_pkg::TW + lom_pkg::PW + lom_pkg::SW;

  logic [lom_pkg::QW-1:0] qty;
  logic [lom_pkg::TW-1:0] trader;
  logic [lom_pkg::PW-1:0] price;
  logic [lom_pkg::SW-1:0] arrival;
  logic                   own_empty;

  logic                   we;
  logic [WW-1:0]          wdata;
  logic [WW-1:0]          rdata;
  logic [lom_pkg::SW-1:0] age;
  logic                   better;
  logic [lom_pkg::XW-1:0] my_idx;

  assign my_idx = lom_pkg::XW'(IDX);
  assign we = ctrl.clr | ctrl.wb | (ctrl.rest && ctrl.rest_idx == my_idx);

  always_comb begin
    if (ctrl.clr) begin
      wdata = '0;
    end else if (ctrl.rest) begin
      wdata = {ctrl.rest_qty, ctrl.rest_trader, ctrl.rest_price, ctrl.arrival_now};
    end else begin
      wdata = {qty, trader, price, arrival};
    end
  end

  lom_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (ctrl.addr[RAW-1:0]),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign age = ctrl.arrival_now - arrival;

  always_comb begin
    if (qty == '0) begin
      better = 1'b0;
    end else if (!cand_in.valid) begin
      better = 1'b1;
    end else if (price != cand_in.price) begin
      better = ctrl.sell ? (price > cand_in.price) : (price < cand_in.price);
    end else begin
      better = age > cand_in.age;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_opp) begin
      {qty, trader, price, arrival} <= rdata;
    end else if (ctrl.fill && ctrl.fill_idx == my_idx) begin
      qty <= qty - ctrl.fill_qty;
    end
    if (ctrl.load_own) begin
      own_empty <= (rdata[WW-1 -: lom_pkg::QW] == '0);
    end
    if (better) begin
      cand_out <= '{valid: 1'b1, price: price, age: age, qty: qty, trader: trader, idx: my_idx};
    end else begin
      cand_out <= cand_in;
    end
    if (free_in.found) begin
      free_out <= free_in;
    end else begin
      free_out <= '{found: own_empty, idx: my_idx};
    end
  end
endmodule

### test/limit_order_matcher_top_tb.sv
`timescale 1ns / 1ps
module limit_order_matcher_top_tb;

  localparam int NINST = 16;
  localparam int DEPTH = 16;
  localparam int LIMIT = 400000;

  typedef struct {
    bit          mode;
    bit [15:0]   trader;
    bit [3:0]    inst;
    bit [19:0]   amount;
    bit [23:0]   cents;
  } order_t;

  typedef struct {
    bit [1:0]  kind;
    bit [3:0]  inst;
    bit [15:0] seller;
    bit [15:0] buyer;
    bit [19:0] amount;
    bit [23:0] cents;
    bit [31:0] seq;
    bit        last;
  } fill_t;

  class match_board;
    bit [19:0] qty_q[NINST*2*DEPTH];
    bit [15:0] trader_q[NINST*2*DEPTH];
    bit [23:0] price_q[NINST*2*DEPTH];
    bit [31:0] arr_q[NINST*2*DEPTH];
    bit [31:0] trades;
    bit [31:0] arrivals;
    fill_t     pending[$];
    int        errors;

    function void clear();
      foreach (qty_q[i]) qty_q[i] = 0;
      trades = 0;
      arrivals = 0;
      errors = 0;
      pending.delete();
    endfunction

    function int best_of(int base, bit is_bid);
      int b;
      bit [23:0] bp;
      bit [31:0] bage;
      bit [31:0] age;
      bit better;
      b = -1;
      bp = 0;
      bage = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (qty_q[base+i] != 0) begin
          age = arrivals - arr_q[base+i];
          if (b < 0) better = 1;
          else if (price_q[base+i] != bp)
            better = is_bid ? (price_q[base+i] > bp) : (price_q[base+i] < bp);
          else better = age > bage;
          if (better) begin
            b = i;
            bp = price_q[base+i];
            bage = age;
          end
        end
      end
      return b;
    endfunction

    function void push(bit [1:0] k, bit [3:0] inst, bit [15:0] s, bit [15:0] b,
                       bit [19:0] a, bit [23:0] c, bit [31:0] q, bit l);
      fill_t f;
      f.kind = k; f.inst = inst; f.seller = s; f.buyer = b;
      f.amount = a; f.cents = c; f.seq = q; f.last = l;
      pending.insert(pending.size(), f);
    endfunction

    function void note_order(order_t o);
      int own, opp, b, s, freeslot;
      bit [19:0] qty, tq;
      bit [23:0] tp;
      bit [15:0] sts, stb;
      qty = o.amount;
      sts = o.mode ? o.trader : 16'd0;
      stb = o.mode ? 16'd0 : o.trader;
      own = (o.inst * 2 + o.mode) * DEPTH;
      opp = (o.inst * 2 + (1 - o.mode)) * DEPTH;
      for (int it = 0; it < DEPTH && qty > 0; it++) begin
        b = best_of(opp, o.mode);
        if (b < 0) break;
        s = opp + b;
        if (o.mode) begin
          if (price_q[s] < o.cents) break;
          tp = o.cents;
        end else begin
          if (price_q[s] > o.cents) break;
          tp = price_q[s];
        end
        tq = qty < qty_q[s] ? qty : qty_q[s];
        if (o.mode) push(lom_pkg::KIND_TRADE, o.inst, o.trader, trader_q[s], tq, tp, trades, 0);
        else push(lom_pkg::KIND_TRADE, o.inst, trader_q[s], o.trader, tq, tp, trades, 0);
        trades++;
        qty -= tq;
        qty_q[s] -= tq;
      end
      if (qty == 0) begin
        push(lom_pkg::KIND_FILLED, o.inst, sts, stb, 0, o.cents, 0, 1);
      end else begin
        freeslot = -1;
        for (int i = 0; i < DEPTH; i++)
          if (freeslot < 0 && qty_q[own+i] == 0) freeslot = i;
        if (freeslot < 0) begin
          push(lom_pkg::KIND_DROPPED, o.inst, sts, stb, qty, o.cents, 0, 1);
        end else begin
          s = own + freeslot;
          qty_q[s] = qty;
          trader_q[s] = o.trader;
          price_q[s] = o.cents;
          arr_q[s] = arrivals;
          push(lom_pkg::KIND_RESTED, o.inst, sts, stb, qty, o.cents, 0, 1);
        end
      end
      arrivals++;
    endfunction

    function void cmp(string name, bit [31:0] e, bit [31:0] a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
      end
    endfunction

    function void check(fill_t a);
      fill_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none actual kind %0d seq %h",
                 $time, a.kind, a.seq);
        return;
      end
      e = pending.pop_front();
      cmp("kind", e.kind, a.kind);
      cmp("instrument_out", e.inst, a.inst);
      cmp("seller", e.seller, a.seller);
      cmp("buyer", e.buyer, a.buyer);
      cmp("fill_amount", e.amount, a.amount);
      cmp("fill_cents", e.cents, a.cents);
      cmp("trade_seq", e.seq, a.seq);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  lom_order_if order ();
  lom_result_if result ();
  match_board board;
  int cycles = 0;
  int sent = 0;
  bit calm = 0;
  bit hold = 0;

  limit_order_matcher_top #(.NUM_INSTRUMENTS(NINST), .BOOK_DEPTH(DEPTH), .PRICE_BITS(24)) dut (
    .clk(clk), .rst(rst), .order(order.sink), .result(result.source)
  );

  always #5 clk = ~clk;

  initial begin
    order.valid = 0;
    order.mode = 0;
    order.trader = 0;
    order.instrument = 0;
    order.amount = 0;
    order.limit_cents = 0;
    result.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && result.valid && result.ready) begin
      fill_t f;
      f.kind = result.kind; f.inst = result.instrument_out;
      f.seller = result.seller; f.buyer = result.buyer;
      f.amount = result.fill_amount; f.cents = result.fill_cents;
      f.seq = result.trade_seq; f.last = result.last;
      board.check(f);
    end

  // receiver, with one long hold-off while the sender keeps offering
  initial begin
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold && held < 600) begin
        result.ready = 0;
        held++;
      end else begin
        result.ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 22);
      end
    end
  end

  task automatic send(bit mode, bit [15:0] trader, bit [3:0] inst, bit [19:0] amount,
                      bit [23:0] cents);
    order_t o;
    o.mode = mode; o.trader = trader; o.inst = inst; o.amount = amount; o.cents = cents;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 22) begin
      order.valid = 0;
      @(negedge clk);
    end
    order.valid = 1;
    order.mode = mode;
    order.trader = trader;
    order.instrument = inst;
    order.amount = amount;
    order.limit_cents = cents;
    do @(posedge clk); while (!order.ready);
    board.note_order(o);
    sent++;
  endtask

  task automatic send_random();
    bit [19:0] amt;
    bit [23:0] px;
    bit [3:0] inst;
    inst = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    amt = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(1, 20'hfffff))
                                      : 20'($urandom_range(1, 60));
    px = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'(5000 + $urandom_range(0, 12));
    send(1'($urandom_range(0, 1)), 16'($urandom), inst, amt, px);
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send(0, 16'h0000, 0, 20'hfffff, 24'hffffff);
    send(1, 16'hffff, 0, 20'd1, 24'h000000);
    send(1, 16'h8001, 0, 20'hfffff, 24'hffffff);
    send(0, 16'h1234, 1, 20'd0, 24'd77);
    for (int i = 0; i < 17; i++) send(0, 16'(i + 1), 15, 20'd10, 24'(100 + i % 4));
    send(1, 16'h4321, 15, 20'hfffff, 24'd0);
    for (int i = 0; i < 160; i++) begin
      calm = (i >= 60 && i < 100);
      if (i == 110) hold = 1;
      send_random();
    end
    @(negedge clk);
    order.valid = 0;
    calm = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
